### sv/segment_intersection_macros.svh
// ---------------------------------------------------------------------------
// segment_intersection_macros
// Assertion macros shared by the segment intersection RTL.
// ---------------------------------------------------------------------------
`ifndef SEGMENT_INTERSECTION_MACROS_SVH
`define SEGMENT_INTERSECTION_MACROS_SVH

// Implication in the same cycle, disabled during reset.
`define SEGX_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication checked in the next cycle, disabled during reset.
`define SEGX_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/segx_pkg.sv
// ---------------------------------------------------------------------------
// segx_pkg
// Widths and carried records for the segment intersection pipeline.
// ---------------------------------------------------------------------------
package segx_pkg;

	localparam int COORD_W   = 32;
	localparam int DIFF_W    = COORD_W + 1;
	localparam int PROD_W    = 2 * DIFF_W;
	localparam int DEN_W     = PROD_W - 1;
	localparam int REM_W     = DEN_W + 2;
	localparam int DIV_STEPS = COORD_W;

	// Values carried alongside the cross products.
	typedef struct packed {
		logic [COORD_W-1:0] p0x;
		logic [COORD_W-1:0] p0y;
		logic [COORD_W-1:0] mx;
		logic [COORD_W-1:0] my;
		logic               negx;
		logic               negy;
	} segx_pay_t;

	// State of one division step, both lanes.
	typedef struct packed {
		logic               hit;
		logic [DEN_W-1:0]   den;
		logic [DEN_W-1:0]   tnum;
		logic [REM_W-1:0]   remx;
		logic [REM_W-1:0]   remy;
		logic [COORD_W-1:0] qx;
		logic [COORD_W-1:0] qy;
		segx_pay_t          pay;
	} segx_div_t;

endpackage

### sv/segment_intersection.sv
// ---------------------------------------------------------------------------
// segment_intersection
// Intersection of two 2D segments in signed fixed point, fully pipelined.
// ---------------------------------------------------------------------------
// Input channel: in_valid/in_ready with the four endpoints P0..P3. Output
// channel: out_valid/out_ready with hit, cross_x and cross_y (zero on a miss).
// A transfer happens on a rising edge where valid and ready are both high.
// The stages register, in order: the differences, the six cross products,
// the subtractions, the sign fix, the range test, the division steps
// (one quotient bit per stage in each lane) and the final add into the
// output register.
// Throughput is one item per cycle while the output is not stalled; every
// stage is a register with a valid bit. When the receiver stalls with a result
// waiting, the whole pipeline holds and in_ready drops; nothing is lost or repeated.
// Reset clears all valid bits; the block is empty and ready afterward.
// ---------------------------------------------------------------------------
`include "segment_intersection_macros.svh"

module segment_intersection import segx_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [COORD_W-1:0] first_start_x,
	input  logic [COORD_W-1:0] first_start_y,
	input  logic [COORD_W-1:0] first_end_x,
	input  logic [COORD_W-1:0] first_end_y,
	input  logic [COORD_W-1:0] second_start_x,
	input  logic [COORD_W-1:0] second_start_y,
	input  logic [COORD_W-1:0] second_end_x,
	input  logic [COORD_W-1:0] second_end_y,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               hit,
	output logic [COORD_W-1:0] cross_x,
	output logic [COORD_W-1:0] cross_y
);

	logic adv;

	logic                     v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [DIFF_W-1:0] s1x_s1, s1y_s1, s2x_s1, s2y_s1, dx_s1, dy_s1;
	logic [COORD_W-1:0]       p0x_s1, p0y_s1;
	logic signed [PROD_W-1:0] pa_s2, pb_s2, pc_s2, pd_s2, pe_s2, pf_s2;
	segx_pay_t                pay_s2, pay_s3, pay_s4;
	logic signed [PROD_W-1:0] den_s3, snum_s3, tnum_s3;
	logic [DEN_W-1:0]         den_s4;
	logic signed [PROD_W-1:0] snum_s4, tnum_s4;
	logic                     dz_s4;
	segx_div_t                div_s5;

	logic                     div_v [DIV_STEPS+1];
	segx_div_t                div_d [DIV_STEPS+1];

	logic                     out_valid_q;
	logic                     hit_q;
	logic [COORD_W-1:0]       cross_x_q, cross_y_q;

	logic [COORD_W-1:0]       ox, oy;
	logic signed [DIFF_W-1:0] mag_x, mag_y;
	logic                     hit_c;
	segx_div_t                fin;

	// The whole pipeline advances unless a result waits on a stalled receiver.
	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;

	// Valid bits of the front stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Magnitudes of the first direction vector for the division lanes.
	always_comb begin
		mag_x = s1x_s1[DIFF_W-1] ? -s1x_s1 : s1x_s1;
		mag_y = s1y_s1[DIFF_W-1] ? -s1y_s1 : s1y_s1;
	end

	// Range test after the sign fix.
	assign hit_c = !dz_s4
		&& !snum_s4[PROD_W-1] && (snum_s4[DEN_W-1:0] <= den_s4)
		&& !tnum_s4[PROD_W-1] && (tnum_s4[DEN_W-1:0] <= den_s4);

	// Front stages: differences, products, cross terms, sign fix, range test.
	always_ff @(posedge clk) begin
		if (adv) begin
			s1x_s1 <= $signed({first_end_x[COORD_W-1], first_end_x})
				- $signed({first_start_x[COORD_W-1], first_start_x});
			s1y_s1 <= $signed({first_end_y[COORD_W-1], first_end_y})
				- $signed({first_start_y[COORD_W-1], first_start_y});
			s2x_s1 <= $signed({second_end_x[COORD_W-1], second_end_x})
				- $signed({second_start_x[COORD_W-1], second_start_x});
			s2y_s1 <= $signed({second_end_y[COORD_W-1], second_end_y})
				- $signed({second_start_y[COORD_W-1], second_start_y});
			dx_s1  <= $signed({first_start_x[COORD_W-1], first_start_x})
				- $signed({second_start_x[COORD_W-1], second_start_x});
			dy_s1  <= $signed({first_start_y[COORD_W-1], first_start_y})
				- $signed({second_start_y[COORD_W-1], second_start_y});
			p0x_s1 <= first_start_x;
			p0y_s1 <= first_start_y;

			pa_s2 <= s1x_s1 * s2y_s1;
			pb_s2 <= s2x_s1 * s1y_s1;
			pc_s2 <= s1x_s1 * dy_s1;
			pd_s2 <= s1y_s1 * dx_s1;
			pe_s2 <= s2x_s1 * dy_s1;
			pf_s2 <= s2y_s1 * dx_s1;
			pay_s2.p0x  <= p0x_s1;
			pay_s2.p0y  <= p0y_s1;
			pay_s2.mx   <= mag_x[COORD_W-1:0];
			pay_s2.my   <= mag_y[COORD_W-1:0];
			pay_s2.negx <= s1x_s1[DIFF_W-1];
			pay_s2.negy <= s1y_s1[DIFF_W-1];

			den_s3  <= pa_s2 - pb_s2;
			snum_s3 <= pc_s2 - pd_s2;
			tnum_s3 <= pe_s2 - pf_s2;
			pay_s3  <= pay_s2;

			if (den_s3[PROD_W-1]) begin
				den_s4  <= DEN_W'(-den_s3);
				snum_s4 <= -snum_s3;
				tnum_s4 <= -tnum_s3;
			end else begin
				den_s4  <= DEN_W'(den_s3);
				snum_s4 <= snum_s3;
				tnum_s4 <= tnum_s3;
			end
			dz_s4  <= (den_s3 == '0);
			pay_s4 <= pay_s3;

			div_s5.hit  <= hit_c;
			div_s5.den  <= den_s4;
			div_s5.tnum <= tnum_s4[DEN_W-1:0];
			div_s5.remx <= '0;
			div_s5.remy <= '0;
			div_s5.qx   <= '0;
			div_s5.qy   <= '0;
			div_s5.pay  <= pay_s4;
		end
	end

	// Division chain, one quotient bit per stage.
	assign div_v[0] = v_s5;
	assign div_d[0] = div_s5;

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		segx_div_stage u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (adv),
			.valid_in  (div_v[k]),
			.d_in      (div_d[k]),
			.valid_out (div_v[k+1]),
			.d_out     (div_d[k+1])
		);
	end

	// Signed offsets from P0.
	always_comb begin
		fin = div_d[DIV_STEPS];
		ox  = fin.pay.negx ? (~fin.qx + COORD_W'(1)) : fin.qx;
		oy  = fin.pay.negy ? (~fin.qy + COORD_W'(1)) : fin.qy;
	end

	// Output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= div_v[DIV_STEPS];
		end
	end

	// Output payload, zeroed on a miss.
	always_ff @(posedge clk) begin
		if (adv) begin
			hit_q     <= fin.hit;
			cross_x_q <= fin.hit ? (fin.pay.p0x + ox) : '0;
			cross_y_q <= fin.hit ? (fin.pay.p0y + oy) : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign hit       = hit_q;
	assign cross_x   = cross_x_q;
	assign cross_y   = cross_y_q;

	`SEGX_ASSERT_SAME(a_miss_zero, out_valid && !hit, cross_x == '0 && cross_y == '0, "miss with nonzero point")
	`SEGX_ASSERT_SAME(a_ready_rule, 1'b1, in_ready == (!out_valid || out_ready), "ready does not follow output stall")
	`SEGX_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(cross_x) && $stable(hit), "stalled result changed")

endmodule

### sv/segx_div_stage.sv
// ---------------------------------------------------------------------------
// segx_div_stage
// One radix-2 step of q = floor(m * tnum / den) for the x and y lanes.
// ---------------------------------------------------------------------------
module segx_div_stage import segx_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      valid_in,
	input  segx_div_t d_in,
	output logic      valid_out,
	output segx_div_t d_out
);

	logic              valid_q;
	segx_div_t         res_q;
	segx_div_t         nxt;
	logic [REM_W-1:0]  den1;
	logic [REM_W-1:0]  den2;
	logic [REM_W-1:0]  tn;
	logic [REM_W-1:0]  rx;
	logic [REM_W-1:0]  ry;

	// Shift in the next multiplier bit, then take off up to two denominators.
	always_comb begin
		den1 = REM_W'(d_in.den);
		den2 = REM_W'({d_in.den, 1'b0});
		tn   = REM_W'(d_in.tnum);
		nxt  = d_in;
		rx = {d_in.remx[REM_W-2:0], 1'b0} + (d_in.pay.mx[COORD_W-1] ? tn : '0);
		ry = {d_in.remy[REM_W-2:0], 1'b0} + (d_in.pay.my[COORD_W-1] ? tn : '0);
		nxt.pay.mx = {d_in.pay.mx[COORD_W-2:0], 1'b0};
		nxt.pay.my = {d_in.pay.my[COORD_W-2:0], 1'b0};
		if (rx >= den2) begin
			nxt.remx = rx - den2;
			nxt.qx   = {d_in.qx[COORD_W-2:0], 1'b0} + COORD_W'(2);
		end else if (rx >= den1) begin
			nxt.remx = rx - den1;
			nxt.qx   = {d_in.qx[COORD_W-2:0], 1'b1};
		end else begin
			nxt.remx = rx;
			nxt.qx   = {d_in.qx[COORD_W-2:0], 1'b0};
		end
		if (ry >= den2) begin
			nxt.remy = ry - den2;
			nxt.qy   = {d_in.qy[COORD_W-2:0], 1'b0} + COORD_W'(2);
		end else if (ry >= den1) begin
			nxt.remy = ry - den1;
			nxt.qy   = {d_in.qy[COORD_W-2:0], 1'b1};
		end else begin
			nxt.remy = ry;
			nxt.qy   = {d_in.qy[COORD_W-2:0], 1'b0};
		end
	end

	// Stage valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= nxt;
		end
	end

	assign valid_out = valid_q;
	assign d_out     = res_q;

endmodule
